// ===== rtl/pa_pkg.sv =====
// ----------------------------------------------------------------------------
// pa_pkg: shared types and constants of the page allocator
// Command and status codes, payload structs, state machine encoding and the
// control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pa_pkg;

  localparam int PAGE_W  = 20;
  localparam int END_W   = 21;
  localparam int COUNT_W = 8;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int unsigned REG_FIRST_PAGE = 0;
  localparam int unsigned REG_END_PAGE   = 1;

  localparam logic [END_W-1:0] END_PAGE_RESET = 21'd32768;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_ADD_REF = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OOM       = 2'd1,
    STAT_BAD_PAGE  = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SWEEP
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [PAGE_W-1:0] page;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [PAGE_W-1:0]  granted_page;
    logic [COUNT_W-1:0] ref_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic sweep_wr;
  } pa_ctrl_t;

  typedef struct packed {
    logic in_init;
    logic sweep_last;
    logic out_busy;
  } pa_stat_t;

endpackage

// ===== rtl/pa_regs.sv =====
// ----------------------------------------------------------------------------
// pa_regs: configuration registers
// APB-style register file holding the first and end page frame numbers.
// ----------------------------------------------------------------------------
module pa_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pa_pkg::ADDR_W-1:0]  paddr,
  input  logic [pa_pkg::DATA_W-1:0]  pwdata,
  output logic [pa_pkg::DATA_W-1:0]  prdata,
  output logic                       pready,
  output logic [pa_pkg::PAGE_W-1:0]  first_page_o,
  output logic [pa_pkg::END_W-1:0]   end_page_o
);

  logic [pa_pkg::PAGE_W-1:0] first_page_q;
  logic [pa_pkg::END_W-1:0]  end_page_q;
  logic                      wr_en;
  logic                      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= '0;
      end_page_q   <= pa_pkg::END_PAGE_RESET;
    end else if (wr_en) begin
      if (reg_idx == 1'(pa_pkg::REG_FIRST_PAGE)) begin
        first_page_q <= pwdata[pa_pkg::PAGE_W-1:0];
      end else begin
        end_page_q <= pwdata[pa_pkg::END_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == 1'(pa_pkg::REG_FIRST_PAGE)) begin
      prdata = pa_pkg::DATA_W'(first_page_q);
    end else begin
      prdata = pa_pkg::DATA_W'(end_page_q);
    end
  end

  assign first_page_o = first_page_q;
  assign end_page_o   = end_page_q;

endmodule

// ===== rtl/pa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pa_ctrl: allocator controller
// Sequences the reset clearing pass, command accept, init sweep and commit.
// ----------------------------------------------------------------------------
module pa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pa_pkg::pa_stat_t stat_i,
  output pa_pkg::pa_ctrl_t ctrl_o
);

  pa_pkg::state_e state_q;
  pa_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pa_pkg::S_CLEAR: begin
        ctrl_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = pa_pkg::S_IDLE;
        end
      end
      pa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = stat_i.in_init ? pa_pkg::S_SWEEP : pa_pkg::S_EXEC;
        end
      end
      pa_pkg::S_SWEEP: begin
        ctrl_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = pa_pkg::S_EXEC;
        end
      end
      pa_pkg::S_EXEC: begin
        if (!stat_i.out_busy) begin
          ctrl_o.commit = 1'b1;
          state_d       = pa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pa_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/pa_datapath.sv =====
// ----------------------------------------------------------------------------
// pa_datapath: allocator datapath
// Free stack and reference count memories, stack depth, window logic,
// sweep counter and the output register.
// ----------------------------------------------------------------------------
module pa_datapath #(
  parameter int NUM_PAGES = 32768,
  parameter int REF_BITS  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pa_pkg::in_item_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pa_pkg::out_item_t          out_data_o,
  input  logic [pa_pkg::PAGE_W-1:0]  first_page_i,
  input  logic [pa_pkg::END_W-1:0]   end_page_i,
  input  pa_pkg::pa_ctrl_t           ctrl_i,
  output pa_pkg::pa_stat_t           stat_o
);

  localparam int OFF_W   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int LIM_W   = pa_pkg::END_W + 1;
  localparam int WIDE_W  = REF_BITS + pa_pkg::COUNT_W;

  logic [OFF_W-1:0]    stk_mem [NUM_PAGES];
  logic [REF_BITS-1:0] cnt_mem [NUM_PAGES];

  logic [DEPTH_W-1:0]  depth_q;
  logic [DEPTH_W-1:0]  depth_d;
  logic [OFF_W-1:0]    sweep_idx_q;
  pa_pkg::cmd_e        cmd_q;
  logic [OFF_W-1:0]    off_q;
  logic                in_win_q;
  logic [REF_BITS-1:0] rd_cnt_q;
  logic [OFF_W-1:0]    rd_stk_q;
  logic                out_valid_q;
  pa_pkg::out_item_t   out_q;

  logic [LIM_W-1:0]          first_ext;
  logic [LIM_W-1:0]          end_ext;
  logic [LIM_W-1:0]          top_ext;
  logic [LIM_W-1:0]          limit;
  logic [LIM_W-1:0]          win_size;
  logic [LIM_W-1:0]          page_ext;
  logic [DEPTH_W-1:0]        win_pages;
  logic [pa_pkg::PAGE_W-1:0] page_diff;
  logic [OFF_W-1:0]          in_off;
  logic                      in_win;
  logic [DEPTH_W-1:0]        depth_m1;
  logic [pa_pkg::PAGE_W-1:0] grant;

  pa_pkg::out_item_t   res;
  logic                cnt_we;
  logic [OFF_W-1:0]    cnt_waddr;
  logic [REF_BITS-1:0] cnt_wdata;
  logic                push;
  logic [REF_BITS-1:0] new_cnt;
  logic [WIDE_W-1:0]   cnt_wide;

  assign first_ext = LIM_W'(first_page_i);
  assign end_ext   = LIM_W'(end_page_i);
  assign top_ext   = first_ext + LIM_W'(NUM_PAGES);
  assign limit     = (end_ext < top_ext) ? end_ext : top_ext;
  assign win_size  = (limit > first_ext) ? (limit - first_ext) : '0;
  assign win_pages = win_size[DEPTH_W-1:0];

  assign page_ext  = LIM_W'(in_data_i.page);
  assign in_win    = (page_ext >= first_ext) && (page_ext < limit);
  assign page_diff = in_data_i.page - first_page_i;
  assign in_off    = page_diff[OFF_W-1:0];
  assign depth_m1  = depth_q - DEPTH_W'(1);
  assign grant     = first_page_i + pa_pkg::PAGE_W'(rd_stk_q);

  always_comb begin
    res       = '0;
    res.status = pa_pkg::STAT_OK;
    cnt_we    = 1'b0;
    cnt_waddr = off_q;
    cnt_wdata = '0;
    push      = 1'b0;
    depth_d   = depth_q;
    new_cnt   = '0;
    case (cmd_q)
      pa_pkg::CMD_INIT: begin
        depth_d = win_pages;
      end
      pa_pkg::CMD_ALLOC: begin
        if (depth_q == '0) begin
          res.status = pa_pkg::STAT_OOM;
        end else begin
          depth_d          = depth_m1;
          cnt_we           = 1'b1;
          cnt_waddr        = rd_stk_q;
          new_cnt          = REF_BITS'(1);
          res.granted_page = grant;
        end
      end
      pa_pkg::CMD_FREE: begin
        if (!in_win_q) begin
          res.status = pa_pkg::STAT_BAD_PAGE;
        end else if (rd_cnt_q == '0) begin
          res.status = pa_pkg::STAT_NOT_ALLOC;
        end else begin
          new_cnt = rd_cnt_q - REF_BITS'(1);
          cnt_we  = 1'b1;
          if ((new_cnt == '0) && (depth_q < DEPTH_W'(NUM_PAGES))) begin
            push    = 1'b1;
            depth_d = depth_q + DEPTH_W'(1);
          end
        end
      end
      pa_pkg::CMD_ADD_REF: begin
        if (!in_win_q) begin
          res.status = pa_pkg::STAT_BAD_PAGE;
        end else begin
          cnt_we  = 1'b1;
          new_cnt = (rd_cnt_q == {REF_BITS{1'b1}}) ? rd_cnt_q : rd_cnt_q + REF_BITS'(1);
        end
      end
      default: begin
        res.status = pa_pkg::STAT_OK;
      end
    endcase
    cnt_wdata = new_cnt;
    cnt_wide  = WIDE_W'(new_cnt);
    if (cnt_we) begin
      res.ref_count = cnt_wide[pa_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sweep_wr) begin
      cnt_mem[sweep_idx_q] <= '0;
      stk_mem[sweep_idx_q] <= sweep_idx_q;
    end else if (ctrl_i.commit) begin
      if (cnt_we) begin
        cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (push) begin
        stk_mem[depth_q[OFF_W-1:0]] <= off_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rd_cnt_q <= cnt_mem[in_off];
      rd_stk_q <= stk_mem[depth_m1[OFF_W-1:0]];
      cmd_q    <= in_data_i.command;
      off_q    <= in_off;
      in_win_q <= in_win;
    end
    if (ctrl_i.commit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      sweep_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.commit) begin
        depth_q <= depth_d;
      end
      if (ctrl_i.sweep_wr) begin
        sweep_idx_q <= stat_o.sweep_last ? '0 : sweep_idx_q + OFF_W'(1);
      end
      if (ctrl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.in_init    = (in_data_i.command == pa_pkg::CMD_INIT);
  assign stat_o.sweep_last = (sweep_idx_q == OFF_W'(NUM_PAGES - 1));
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(NUM_PAGES))
    else $error("free stack depth above page count");

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("commit while output register is occupied");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |=> out_valid_q)
    else $error("commit did not raise output valid");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.sweep_wr && (ctrl_i.commit || ctrl_i.load)))
    else $error("sweep overlaps a command");
`endif

endmodule

// ===== rtl/page_allocator_with_refcounts.sv =====
// ----------------------------------------------------------------------------
// page_allocator_with_refcounts: page frame allocator with reference counts
// Input channel in_valid_i/in_ready_o/in_data_i carries a command (init,
// alloc, free, add reference) and a page frame number; the output channel
// out_valid_o/out_ready_i/out_data_o returns one result per transaction:
// status, granted page and the page's count after the operation.
// Alloc, free and add reference read the count and stack memories into
// registers on accept; in S_EXEC they write them back and load the output
// register. Init first runs a sweep that writes one count and one stack entry
// per cycle, then commits like the other commands.
// After reset a clearing pass zeroes the counts; no transaction is accepted
// during it, configuration writes are taken.
// A result waiting in the output register does not block accept of the next
// transaction; that transaction holds before commit while the receiver stalls.
// The APB-style port sets first_page (0x0) and end_page (0x4).
// ----------------------------------------------------------------------------
module page_allocator_with_refcounts #(
  parameter int NUM_PAGES = 32768,
  parameter int REF_BITS  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pa_pkg::in_item_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pa_pkg::out_item_t          out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pa_pkg::ADDR_W-1:0]  paddr,
  input  logic [pa_pkg::DATA_W-1:0]  pwdata,
  output logic [pa_pkg::DATA_W-1:0]  prdata,
  output logic                       pready
);

  logic [pa_pkg::PAGE_W-1:0] first_page;
  logic [pa_pkg::END_W-1:0]  end_page;
  pa_pkg::pa_ctrl_t          ctrl;
  pa_pkg::pa_stat_t          stat;

  pa_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .first_page_o (first_page),
    .end_page_o   (end_page)
  );

  pa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pa_datapath #(
    .NUM_PAGES (NUM_PAGES),
    .REF_BITS  (REF_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .first_page_i (first_page),
    .end_page_i   (end_page),
    .ctrl_i       (ctrl),
    .stat_o       (stat)
  );

endmodule

// ===== verif/tb_page_allocator_with_refcounts.sv =====
// ----------------------------------------------------------------------------
// tb_page_allocator_with_refcounts: self-checking testbench of the allocator
// A queue-fed driver sends commands on the input channel. A monitor compares
// each result, field by field, with the output of a behavioral model of the
// free stack and the per-page counts. A short directed run comes first. Three
// random phases follow, each with its own window and its own idle pattern.
// Register writes are read back over the APB-style port.
// ----------------------------------------------------------------------------
module tb_page_allocator_with_refcounts;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES = 32768;
  localparam int REF_BITS = 8;
  localparam int OFFSET_W = $clog2(NUM_PAGES);
  localparam logic [pa_pkg::COUNT_W-1:0] REF_MAX = '1;
  localparam longint unsigned PAGE_SPACE = 64'd1048576;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pa_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pa_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pa_pkg::ADDR_W-1:0] paddr = '0;
  logic [pa_pkg::DATA_W-1:0] pwdata = '0;
  logic [pa_pkg::DATA_W-1:0] prdata;
  logic pready;

  page_allocator_with_refcounts #(
    .NUM_PAGES(NUM_PAGES),
    .REF_BITS (REF_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  logic [pa_pkg::PAGE_W-1:0] cfg_first = '0;
  logic [pa_pkg::END_W-1:0] cfg_end = pa_pkg::END_PAGE_RESET;
  logic [pa_pkg::COUNT_W-1:0] page_counts [NUM_PAGES];
  logic [OFFSET_W-1:0] free_offsets [NUM_PAGES];
  int unsigned free_depth = 0;

  pa_pkg::in_item_t command_queue [$];
  pa_pkg::out_item_t pending_responses [$];
  int unsigned n_queued = 0;
  int unsigned n_commands = 0;
  int unsigned n_results = 0;
  int unsigned n_inits = 0;
  int unsigned n_oom = 0;
  int unsigned n_bad = 0;
  int unsigned n_not_alloc = 0;
  int unsigned n_saturated = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  int send_idle = 22;
  int recv_idle = 59;

  initial begin
    foreach (page_counts[i]) page_counts[i] = '0;
    foreach (free_offsets[i]) free_offsets[i] = '0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  function automatic longint unsigned window_limit();
    longint unsigned lim;
    lim = longint'(cfg_first) + NUM_PAGES;
    if (longint'(cfg_end) < lim) lim = longint'(cfg_end);
    return lim;
  endfunction

  function automatic pa_pkg::out_item_t expected_response(input pa_pkg::in_item_t cmd);
    pa_pkg::out_item_t rsp;
    longint unsigned lim;
    int unsigned span;
    int unsigned off;
    rsp = '0;
    rsp.status = pa_pkg::STAT_OK;
    lim = window_limit();
    case (cmd.command)
      pa_pkg::CMD_INIT: begin
        n_inits++;
        span = (lim > cfg_first) ? int'(lim - cfg_first) : 0;
        foreach (page_counts[i]) page_counts[i] = '0;
        for (int i = 0; i < span; i++) free_offsets[i] = OFFSET_W'(i);
        free_depth = span;
      end
      pa_pkg::CMD_ALLOC: begin
        if (free_depth == 0) begin
          rsp.status = pa_pkg::STAT_OOM;
          n_oom++;
        end else begin
          free_depth--;
          off = free_offsets[free_depth];
          page_counts[off] = 8'd1;
          rsp.granted_page = pa_pkg::PAGE_W'(cfg_first + off);
          rsp.ref_count = 8'd1;
        end
      end
      default: begin
        if (cmd.page < cfg_first || longint'(cmd.page) >= lim) begin
          rsp.status = pa_pkg::STAT_BAD_PAGE;
          n_bad++;
        end else begin
          off = cmd.page - cfg_first;
          if (cmd.command == pa_pkg::CMD_FREE) begin
            if (page_counts[off] == 0) begin
              rsp.status = pa_pkg::STAT_NOT_ALLOC;
              n_not_alloc++;
            end else begin
              page_counts[off]--;
              if (page_counts[off] == 0 && free_depth < NUM_PAGES) begin
                free_offsets[free_depth] = OFFSET_W'(off);
                free_depth++;
              end
              rsp.ref_count = page_counts[off];
            end
          end else begin
            if (page_counts[off] != REF_MAX) page_counts[off]++;
            else n_saturated++;
            rsp.ref_count = page_counts[off];
          end
        end
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i) begin : command_driver
    logic busy;
    busy = in_valid_i;
    if (in_valid_i && in_ready_o) begin
      pending_responses.push_back(expected_response(in_data_i));
      n_commands++;
      busy = 1'b0;
    end
    if (!busy) begin
      if (rst_ni && command_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_data_i <= command_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    pa_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected result, status", out_data_o.status, -1);
      end else begin
        want = pending_responses.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.granted_page !== want.granted_page)
          report_mismatch("granted_page", out_data_o.granted_page, want.granted_page);
        if (out_data_o.ref_count !== want.ref_count)
          report_mismatch("ref_count", out_data_o.ref_count, want.ref_count);
      end
      n_results++;
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_register(input int unsigned idx, input logic [pa_pkg::DATA_W-1:0] value);
    logic [pa_pkg::DATA_W-1:0] readback;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pa_pkg::ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == pa_pkg::REG_FIRST_PAGE) cfg_first = value[pa_pkg::PAGE_W-1:0];
    else cfg_end = value[pa_pkg::END_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) report_mismatch("register readback", readback, value);
  endtask

  task automatic set_window(input longint unsigned first, input longint unsigned last);
    write_register(pa_pkg::REG_FIRST_PAGE, pa_pkg::DATA_W'(first));
    write_register(pa_pkg::REG_END_PAGE, pa_pkg::DATA_W'(last));
  endtask

  task automatic push_command(input pa_pkg::cmd_e op, input logic [pa_pkg::PAGE_W-1:0] page);
    pa_pkg::in_item_t cmd;
    cmd.command = op;
    cmd.page = page;
    command_queue.push_back(cmd);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_commands != n_queued || pending_responses.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [pa_pkg::PAGE_W-1:0] pick_page(input int unsigned hint);
    longint unsigned lim;
    longint unsigned span;
    int unsigned reach;
    int unsigned r;
    lim = window_limit();
    span = (lim > cfg_first) ? lim - cfg_first : 0;
    r = $urandom_range(0, 99);
    if (span == 0 || r >= 90) return pa_pkg::PAGE_W'($urandom());
    reach = (span - 1 < hint) ? int'(span - 1) : hint;
    if (r < 70) return pa_pkg::PAGE_W'(lim - 1 - $urandom_range(0, reach));
    if (r < 80) return pa_pkg::PAGE_W'(cfg_first + $urandom_range(0, int'(span - 1)));
    case (r % 4)
      0: return pa_pkg::PAGE_W'(cfg_first - 1);
      1: return pa_pkg::PAGE_W'(lim);
      2: return cfg_first;
      default: return pa_pkg::PAGE_W'(lim - 1);
    endcase
  endfunction

  task automatic queue_random(input int count, input int w_alloc, input int w_free,
                              input int w_add, input int unsigned hint);
    int r;
    pa_pkg::cmd_e op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_alloc) begin
        push_command(pa_pkg::CMD_ALLOC, pa_pkg::PAGE_W'($urandom()));
      end else if (r < w_alloc + w_free) begin
        push_command(pa_pkg::CMD_FREE, pick_page(hint));
      end else if (r < w_alloc + w_free + w_add) begin
        push_command(pa_pkg::CMD_ADD_REF, pick_page(hint));
      end else begin
        case ($urandom_range(0, 2))
          0: op = pa_pkg::CMD_ALLOC;
          1: op = pa_pkg::CMD_FREE;
          default: op = pa_pkg::CMD_ADD_REF;
        endcase
        push_command(op, pa_pkg::PAGE_W'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    longint unsigned first;
    longint unsigned last;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_window(0, pa_pkg::END_PAGE_RESET);
    push_command(pa_pkg::CMD_ALLOC, 20'd0);
    push_command(pa_pkg::CMD_FREE, 20'd5);
    push_command(pa_pkg::CMD_ADD_REF, 20'd5);
    push_command(pa_pkg::CMD_FREE, 20'd5);
    push_command(pa_pkg::CMD_ALLOC, 20'hFFFFF);
    push_command(pa_pkg::CMD_FREE, 20'd32768);
    push_command(pa_pkg::CMD_ADD_REF, 20'hFFFFF);
    push_command(pa_pkg::CMD_INIT, 20'hFFFFF);
    push_command(pa_pkg::CMD_ADD_REF, 20'd0);
    push_command(pa_pkg::CMD_FREE, 20'd0);
    push_command(pa_pkg::CMD_ALLOC, 20'd0);
    push_command(pa_pkg::CMD_ADD_REF, 20'd32767);
    push_command(pa_pkg::CMD_FREE, 20'd32767);
    push_command(pa_pkg::CMD_FREE, 20'd32767);
    push_command(pa_pkg::CMD_FREE, 20'd32767);
    push_command(pa_pkg::CMD_ALLOC, 20'd0);
    wait_drained();

    // keep the stack from the old window: offsets now wrap past the page space
    set_window(PAGE_SPACE - 1, PAGE_SPACE);
    push_command(pa_pkg::CMD_ALLOC, 20'd0);
    push_command(pa_pkg::CMD_ADD_REF, 20'hFFFFF);
    push_command(pa_pkg::CMD_FREE, 20'hFFFFE);
    push_command(pa_pkg::CMD_INIT, 20'd0);
    push_command(pa_pkg::CMD_ALLOC, 20'd0);
    push_command(pa_pkg::CMD_ALLOC, 20'd0);
    wait_drained();

    set_window(0, 0);
    push_command(pa_pkg::CMD_INIT, 20'd0);
    push_command(pa_pkg::CMD_ALLOC, 20'd0);
    push_command(pa_pkg::CMD_FREE, 20'd0);
    wait_drained();

    send_idle = 22;
    recv_idle = 59;
    set_window(1000000, PAGE_SPACE);
    push_command(pa_pkg::CMD_INIT, 20'd0);
    queue_random(230, 40, 32, 24, 64);
    wait_drained();
    push_command(pa_pkg::CMD_INIT, 20'd0);
    queue_random(230, 40, 32, 24, 64);
    wait_drained();

    send_idle = 59;
    recv_idle = 22;
    first = $urandom_range(0, 1048572);
    set_window(first, first + 3);
    push_command(pa_pkg::CMD_INIT, 20'd0);
    queue_random(280, 8, 8, 80, 0);
    wait_drained();
    queue_random(280, 8, 8, 80, 0);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    first = $urandom_range(0, 1048575);
    last = first + $urandom_range(0, 40000);
    if (last > PAGE_SPACE) last = PAGE_SPACE;
    set_window(first, last);
    push_command(pa_pkg::CMD_INIT, 20'd0);
    queue_random(200, 40, 32, 24, 64);
    wait_drained();
    queue_random(200, 40, 32, 24, 64);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (pending_responses.size() != 0)
      report_mismatch("results still outstanding", 0, pending_responses.size());
    $display("ran %0d commands and checked %0d results over %0d inits",
             n_commands, n_results, n_inits);
    $display("out of memory %0d, bad page %0d, not allocated %0d, saturated add-ref %0d",
             n_oom, n_bad, n_not_alloc, n_saturated);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pa_pkg.sv
rtl/pa_regs.sv
rtl/pa_ctrl.sv
rtl/pa_datapath.sv
rtl/page_allocator_with_refcounts.sv
verif/tb_page_allocator_with_refcounts.sv
